// File: rtl/wst2d_pkg.sv
// package for the weighted 2d stencil filter
// constants, config register indexes, sequencer states and a reach clamp helper
// no dependencies
package wst2d_pkg;

	localparam int MaxReach   = 2;
	localparam int MaxRow     = 1024;
	localparam int SampleBits = 16;
	localparam int Span       = 2 * MaxReach + 1;
	localparam int Taps       = Span * Span;
	localparam int Lines      = 2 * MaxReach;
	localparam int AccBits    = 40;
	localparam int ColBits    = $clog2(MaxRow);
	localparam int RowBits    = $clog2(Lines + 1);
	localparam int TapBits    = $clog2(Taps);
	localparam int SpanBits   = $clog2(Span);
	localparam int LineBits   = $clog2(Lines);
	localparam int CfgBits    = 16;
	localparam int CfgIdxBits = 3;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_REACH_UP    = 3'd0,
		REG_REACH_DOWN  = 3'd1,
		REG_REACH_LEFT  = 3'd2,
		REG_REACH_RIGHT = 3'd3,
		REG_ROW_WIDTH   = 3'd4,
		REG_DIVISOR     = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_MAC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef logic signed [SampleBits-1:0] sample_t;

	function automatic logic [1:0] clamp_reach(input logic [1:0] r);
		return (r > 2'(MaxReach)) ? 2'(MaxReach) : r;
	endfunction

endpackage

// File: rtl/wst2d_if.sv
// valid/ready channel interfaces for the stencil filter
// depends on wst2d_pkg
interface wst2d_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [4:0]                    weight_index;
	logic signed [15:0]            weight_value;
	logic signed [wst2d_pkg::SampleBits-1:0] sample;
	logic                          frame_start;
	modport source (output valid, action, weight_index, weight_value, sample, frame_start,
		input ready);
	modport sink (input valid, action, weight_index, weight_value, sample, frame_start,
		output ready);
endinterface

interface wst2d_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] filtered;
	logic               clipped;
	logic               row_done;
	modport source (output valid, filtered, clipped, row_done, input ready);
	modport sink (input valid, filtered, clipped, row_done, output ready);
endinterface

// File: rtl/wst2d_div.sv
// serial restoring divider: 40-bit signed dividend by 16-bit unsigned divisor
// truncates toward zero, saturates to 16 bits; depends on wst2d_pkg
module wst2d_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [wst2d_pkg::AccBits-1:0]  dividend,
	input  logic [15:0]                           divisor,
	output logic                                  done,
	output logic signed [15:0]                    quot,
	output logic                                  clip
);
	import wst2d_pkg::*;

	localparam int CntBits = $clog2(AccBits + 1);

	logic [AccBits-1:0] mag_q;
	logic [15:0]        rem_q;
	logic [15:0]        dsr_q;
	logic               neg_q;
	logic               busy_q;
	logic [CntBits-1:0] cnt_q;
	logic [16:0]        trial;
	logic [17:0]        diff;
	logic               big;
	logic signed [AccBits:0] sq;

	assign trial = {rem_q, mag_q[AccBits-1]};
	assign diff  = {1'b0, trial} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(AccBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[AccBits-1];
			mag_q <= dividend[AccBits-1] ? AccBits'(-dividend) : dividend;
			rem_q <= '0;
			dsr_q <= (divisor == '0) ? 16'd1 : divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[15:0];
				mag_q <= {mag_q[AccBits-2:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				mag_q <= {mag_q[AccBits-2:0], 1'b0};
			end
		end
	end

	// magnitude below 2^40 after negation of min value reads as unsigned
	assign sq  = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
	assign big = (sq > 41'sd32767) || (sq < -41'sd32768);
	assign clip = big;
	assign quot = (sq > 41'sd32767) ? 16'sh7fff :
		(sq < -41'sd32768) ? 16'sh8000 : sq[15:0];

endmodule

// File: rtl/weighted_stencil_2d_top.sv
// weighted 2d stencil filter top level
// depends on wst2d_pkg, wst2d_if, wst2d_div
//
// usage:
//  in channel beats carry either a weight write (action 0) or one raster sample
//  (action 1) in row-major order; frame_start restarts row and column counters.
//  the config port (cfg_we, cfg_idx, cfg_data) sets reaches, row width and
//  divisor, which the user must write only while the block is idle (unchecked).
//  a sample whose window lies fully inside the frame yields one out beat:
//  filtered quotient, clipped flag, row_done on the last column of a row.
// sequence:
//  a weight write is taken while idle. a sample is worked in steps: read the line
//  memory, shift the window, walk the taps on the shared multiply-accumulate
//  (up to 25 taps, zero weights add nothing), then run the serial divider.
//  out.valid rises once the divider is done; a sample whose window is outside
//  the frame returns to idle after the shift and makes no result.
//  in.ready is low while a sample is being worked on and while a result waits.
// reset: weights clear, counters clear, config returns to its reset values;
//  line memory contents are undefined until written.
// stall: a result is held in the output register until out.ready.
module weighted_stencil_2d_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	wst2d_in_if.sink                               in,
	wst2d_out_if.source                            out,
	input  logic                                   cfg_we,
	input  logic [wst2d_pkg::CfgIdxBits-1:0]       cfg_idx,
	input  logic [wst2d_pkg::CfgBits-1:0]          cfg_data
);
	import wst2d_pkg::*;

	logic [1:0]         up_q, dn_q, lf_q, rt_q;
	logic [10:0]        width_q;
	logic [15:0]        divisor_q;

	logic signed [15:0] weight_q [Taps];
	sample_t            win_q [Span][Span];
	sample_t            line_mem [Lines * MaxRow];
	sample_t            col_s1 [Lines];

	state_t             state_q, state_d;
	logic [ColBits:0]   colcnt_q;
	logic [RowBits-1:0] rows_q;
	logic [ColBits-1:0] c_q;
	logic               last_q, valid_q;
	logic [LineBits:0]  ln_q;
	sample_t            samp_q;
	logic [SpanBits-1:0] ti_q, tj_q;
	logic               walk_done_q;
	logic signed [AccBits-1:0] acc_q;
	logic signed [31:0] prod_s1;
	logic               prod_v_s1;

	logic [1:0]  up, dn, lf, rt;
	logic [ColBits:0] width;
	logic        in_fire, div_done, div_clip;
	logic signed [15:0] div_quot;

	logic [ColBits:0]   cc0, cnext;
	logic [RowBits-1:0] r0, rnext;
	logic [2:0]         vspan, hspan;
	logic               tap_last;
	logic [TapBits-1:0] tap_idx;

	assign up = clamp_reach(up_q);
	assign dn = clamp_reach(dn_q);
	assign lf = clamp_reach(lf_q);
	assign rt = clamp_reach(rt_q);
	assign width = (width_q == '0) ? (ColBits+1)'(1) :
		((width_q > 11'(MaxRow)) ? (ColBits+1)'(MaxRow) : (ColBits+1)'(width_q));
	assign vspan = 3'(up) + 3'(dn);
	assign hspan = 3'(lf) + 3'(rt);

	assign in.ready = (state_q == ST_IDLE);
	assign in_fire  = in.valid && in.ready;

	// column/row bookkeeping for an incoming sample
	always_comb begin
		cc0 = in.frame_start ? '0 : colcnt_q;
		r0  = in.frame_start ? '0 : rows_q;
		if (cc0 >= width) begin
			cc0 = '0;
			if (r0 < RowBits'(Lines)) r0 = r0 + 1'b1;
		end
		cnext = cc0 + 1'b1;
		rnext = r0;
		if (cnext >= width) begin
			cnext = '0;
			if (rnext < RowBits'(Lines)) rnext = rnext + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= 2'd1; dn_q <= 2'd1; lf_q <= 2'd1; rt_q <= 2'd1;
			width_q <= 11'd1024;
			divisor_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_REACH_UP:    up_q <= cfg_data[1:0];
				REG_REACH_DOWN:  dn_q <= cfg_data[1:0];
				REG_REACH_LEFT:  lf_q <= cfg_data[1:0];
				REG_REACH_RIGHT: rt_q <= cfg_data[1:0];
				REG_ROW_WIDTH:   width_q <= cfg_data[10:0];
				REG_DIVISOR:     divisor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Taps; k++) weight_q[k] <= '0;
		end else if (in_fire && !in.action && in.weight_index < 5'(Taps)) begin
			weight_q[in.weight_index[TapBits-1:0]] <= in.weight_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			colcnt_q <= '0;
			rows_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire && in.action) begin
				colcnt_q <= cnext;
				rows_q   <= rnext;
			end
		end
	end

	assign tap_idx  = TapBits'(ti_q) * TapBits'(Span) + TapBits'(tj_q);
	assign tap_last = (3'(ti_q) == vspan) && (3'(tj_q) == hspan);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire && in.action) state_d = ST_LOAD;
			ST_LOAD:  if (ln_q == (LineBits+1)'(Lines)) state_d = ST_SHIFT;
			ST_SHIFT: state_d = valid_q ? ST_MAC : ST_IDLE;
			ST_MAC:   if (walk_done_q) state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_OUT;
			ST_OUT:   if (out.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// line memory: one read per cycle during load, writes also during load
	logic [LineBits:0] rd_ln;
	sample_t           rd_s1;
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && ln_q < (LineBits+1)'(Lines))
			rd_s1 <= line_mem[{ln_q[LineBits-1:0], c_q}];
		if (state_q == ST_SHIFT || state_q == ST_LOAD) begin
			if (state_q == ST_LOAD && ln_q > '0) begin
				// store col[ln-2], or the new sample when ln is 1, into line ln-1 after that slot was read
				line_mem[{LineBits'(rd_ln - 1'b1), c_q}] <=
					(rd_ln == (LineBits+1)'(1)) ? samp_q : col_s1[LineBits'(rd_ln - 2'd2)];
			end
		end
	end
	assign rd_ln = ln_q;

	always_ff @(posedge clk) begin
		if (in_fire && in.action) begin
			samp_q  <= in.sample;
			c_q     <= cc0[ColBits-1:0];
			last_q  <= (cc0 == width - 1'b1);
			valid_q <= (r0 >= RowBits'(vspan)) && (cc0 >= (ColBits+1)'(hspan));
			ln_q    <= '0;
		end else if (state_q == ST_LOAD) begin
			ln_q <= ln_q + 1'b1;
			if (ln_q > '0) col_s1[LineBits'(ln_q - 1'b1)] <= rd_s1;
		end
		if (state_q == ST_SHIFT) begin
			for (int a = 0; a < Span; a++) begin
				for (int b = Span - 1; b > 0; b--) win_q[a][b] <= win_q[a][b-1];
			end
			win_q[0][0] <= samp_q;
			for (int a = 1; a < Span; a++) begin
				win_q[a][0] <= col_s1[a-1];
			end
			ti_q <= '0;
			tj_q <= '0;
			walk_done_q <= 1'b0;
			acc_q <= '0;
			prod_v_s1 <= 1'b0;
		end else if (state_q == ST_MAC) begin
			prod_v_s1 <= 1'b0;
			if (prod_v_s1) acc_q <= acc_q + AccBits'(prod_s1);
			if (!walk_done_q) begin
				if (weight_q[tap_idx] != '0) begin
					prod_s1 <= weight_q[tap_idx] *
						win_q[vspan - 3'(ti_q)][hspan - 3'(tj_q)];
					prod_v_s1 <= 1'b1;
				end
				if (tap_last) begin
					walk_done_q <= 1'b1;
				end else if (3'(tj_q) == hspan) begin
					tj_q <= '0;
					ti_q <= ti_q + 1'b1;
				end else begin
					tj_q <= tj_q + 1'b1;
				end
			end
		end
	end

	wst2d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MAC && state_d == ST_DIV),
		.dividend (acc_q + ((prod_v_s1) ? AccBits'(prod_s1) : '0)),
		.divisor  (divisor_q),
		.done     (div_done),
		.quot     (div_quot),
		.clip     (div_clip)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			out.filtered <= div_quot;
			out.clipped  <= div_clip;
			out.row_done <= last_q;
		end
	end
	assign out.valid = (state_q == ST_OUT);

endmodule
